>>> src/tbpc_pkg.sv
// Package with shared types and constants of the three-button press classifier.
`default_nettype none

package tbpc_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned NUM_BTN = 3;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd1;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd3000;

    // Button positions in level and flag vectors.
    localparam int unsigned BTN_REC = 0;
    localparam int unsigned BTN_CUR = 1;
    localparam int unsigned BTN_SEL = 2;

    typedef enum logic [1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_SHORT_MIN  = 2'd1,
        CFG_SHORT_MAX  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_IDLE      = 2'd0,
        STATUS_RECORDING = 2'd1,
        STATUS_TRANSMIT  = 2'd2,
        STATUS_OTHER     = 2'd3
    } sys_status_t;

    typedef enum logic [1:0] {
        REC_NONE        = 2'd0,
        REC_STOP        = 2'd1,
        REC_START       = 2'd2,
        REC_CLOSE_START = 2'd3
    } rec_action_t;

    typedef enum logic [2:0] {
        BTN_ACT_NONE    = 3'd0,
        BTN_ACT_MENU    = 3'd1,
        BTN_ACT_ENTER   = 3'd2,
        BTN_ACT_REFUSED = 3'd3,
        BTN_ACT_INVALID = 3'd4
    } btn_action_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] short_min_ms;
        logic [CFG_W-1:0] short_max_ms;
    } cfg_t;

    // Input word layout, highest bit first.
    typedef struct packed {
        logic               menu_open;
        logic [1:0]         system_status;
        logic               select_level;
        logic               cursor_level;
        logic               record_level;
        logic [STAMP_W-1:0] now_ms;
    } poll_t;

    // Result word layout, highest bit first.
    typedef struct packed {
        btn_action_t select_action;
        btn_action_t cursor_action;
        rec_action_t record_action;
    } actions_t;

    typedef struct packed {
        logic [NUM_BTN-1:0]              prev_levels;
        logic [NUM_BTN-1:0][STAMP_W-1:0] press_stamp;
        logic [NUM_BTN-1:0]              held_flags;
        logic                            long_fired;
    } btn_state_t;

endpackage

`default_nettype wire

>>> src/tbpc_decide.sv
// Combinational press classification and next button state for one poll.
`default_nettype none

module tbpc_decide (
    input  wire tbpc_pkg::poll_t      poll,
    input  wire tbpc_pkg::btn_state_t st,
    input  wire tbpc_pkg::cfg_t       cfg,
    output tbpc_pkg::btn_state_t      st_next,
    output tbpc_pkg::actions_t        acts
);

    logic [tbpc_pkg::NUM_BTN-1:0] levels;

    assign levels = {poll.select_level, poll.cursor_level, poll.record_level};

    always_comb begin
        logic [1:0]                  status;
        logic                        menu;
        logic                        rec_edge;
        logic [tbpc_pkg::STAMP_W-1:0] dur;
        tbpc_pkg::btn_action_t       act;

        st_next  = st;
        acts     = '{select_action: tbpc_pkg::BTN_ACT_NONE,
                     cursor_action: tbpc_pkg::BTN_ACT_NONE,
                     record_action: tbpc_pkg::REC_NONE};
        status   = poll.system_status;
        menu     = poll.menu_open;

        // Record button: long press fires once per hold.
        rec_edge = levels[tbpc_pkg::BTN_REC] & ~st.prev_levels[tbpc_pkg::BTN_REC];
        if (rec_edge) begin
            st_next.press_stamp[tbpc_pkg::BTN_REC] = poll.now_ms;
            st_next.held_flags[tbpc_pkg::BTN_REC]  = 1'b1;
            st_next.long_fired                     = 1'b0;
        end
        dur = poll.now_ms - st_next.press_stamp[tbpc_pkg::BTN_REC];
        if (levels[tbpc_pkg::BTN_REC] && st_next.held_flags[tbpc_pkg::BTN_REC]
                && !st_next.long_fired
                && dur >= {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}}, cfg.long_press_ms}) begin
            st_next.long_fired = 1'b1;
            if (status == tbpc_pkg::STATUS_RECORDING) begin
                acts.record_action = tbpc_pkg::REC_STOP;
                status             = tbpc_pkg::STATUS_IDLE;
            end else if (status != tbpc_pkg::STATUS_TRANSMIT) begin
                acts.record_action = menu ? tbpc_pkg::REC_CLOSE_START : tbpc_pkg::REC_START;
                menu               = 1'b0;
                status             = tbpc_pkg::STATUS_RECORDING;
            end
        end
        if (!levels[tbpc_pkg::BTN_REC] && st.prev_levels[tbpc_pkg::BTN_REC]) begin
            st_next.held_flags[tbpc_pkg::BTN_REC] = 1'b0;
        end

        // Cursor then select: short press judged on release.
        for (int i = tbpc_pkg::BTN_CUR; i <= tbpc_pkg::BTN_SEL; i++) begin
            act = tbpc_pkg::BTN_ACT_NONE;
            if (levels[i] && !st.prev_levels[i]) begin
                st_next.press_stamp[i] = poll.now_ms;
                st_next.held_flags[i]  = 1'b1;
            end
            dur = poll.now_ms - st.press_stamp[i];
            if (!levels[i] && st.prev_levels[i] && st.held_flags[i]) begin
                st_next.held_flags[i] = 1'b0;
                if (dur >= {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}}, cfg.short_min_ms}
                        && dur < {{(tbpc_pkg::STAMP_W-tbpc_pkg::CFG_W){1'b0}},
                                  cfg.short_max_ms}) begin
                    if (menu) begin
                        act = tbpc_pkg::BTN_ACT_MENU;
                    end else if (status == tbpc_pkg::STATUS_IDLE) begin
                        menu = 1'b1;
                        act  = tbpc_pkg::BTN_ACT_ENTER;
                    end else begin
                        act = tbpc_pkg::BTN_ACT_REFUSED;
                    end
                end else begin
                    act = tbpc_pkg::BTN_ACT_INVALID;
                end
            end
            if (i == tbpc_pkg::BTN_CUR) begin
                acts.cursor_action = act;
            end else begin
                acts.select_action = act;
            end
        end

        st_next.prev_levels = levels;
    end

endmodule

`default_nettype wire

>>> src/three_button_press_classifier_core.sv
// Top level of the three-button press classifier: registers, handshake and output stage.
//
//  channel  dir  handshake          word layout
//  s_       in   s_tvalid/s_tready  s_tdata: now_ms, record, cursor, select, status, menu
//  m_       out  m_tvalid/m_tready  m_tdata: record_action, cursor_action, select_action
//  cfg_     in   cfg_wr_en          cfg_addr, cfg_wdata
//
// One word per cycle while results are read at once; each result appears in the cycle after its poll is taken.
// The button state updates at the accept edge, so the next poll sees it at once.
// The output register frees in the cycle it is read, so the input stalls only while
// a result waits on m_tready low.
// Reset (aresetn low, synchronous) clears button state and the output valid flag and loads the default timings.
`default_nettype none

module three_button_press_classifier_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] record_level, [33] cursor_level, [34] select_level,
    // [36:35] system_status, [37] menu_open, [39:38] zero
    input  wire  [39:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [1:0] record_action, [4:2] cursor_action, [7:5] select_action
    output logic [7:0]  m_tdata,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [15:0] cfg_wdata
);

    tbpc_pkg::cfg_t       cfg_reg;
    tbpc_pkg::btn_state_t state_reg;
    tbpc_pkg::btn_state_t state_next;
    tbpc_pkg::poll_t      poll;
    tbpc_pkg::actions_t   acts;
    tbpc_pkg::actions_t   out_reg;
    logic                 out_valid_reg;
    logic                 accept;

    assign poll     = s_tdata[$bits(tbpc_pkg::poll_t)-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    tbpc_decide u_decide (
        .poll    (poll),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .acts    (acts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms <= tbpc_pkg::LONG_PRESS_RST;
            cfg_reg.short_min_ms  <= tbpc_pkg::SHORT_MIN_RST;
            cfg_reg.short_max_ms  <= tbpc_pkg::SHORT_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tbpc_pkg::CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_wdata;
                tbpc_pkg::CFG_SHORT_MIN:  cfg_reg.short_min_ms  <= cfg_wdata;
                tbpc_pkg::CFG_SHORT_MAX:  cfg_reg.short_max_ms  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= acts;
        end
    end

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while a result waits");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted poll produced no result");

    a_record_fires_once: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && acts.record_action != tbpc_pkg::REC_NONE |=> state_reg.long_fired)
        else $error("record action without fired flag");

    a_cursor_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && acts.cursor_action != tbpc_pkg::BTN_ACT_NONE
            |=> !state_reg.held_flags[tbpc_pkg::BTN_CUR])
        else $error("cursor held flag kept after release");

endmodule

`default_nettype wire

>>> tb/sv/three_button_press_classifier_core_tb.sv
// Self-checking testbench for the three-button press classifier core.
`default_nettype none

module three_button_press_classifier_core_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [1:0]  CFG_ADDR_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata   = '0;
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = tbpc_pkg::CFG_LONG_PRESS;
    logic [15:0] cfg_wdata = '0;

    three_button_press_classifier_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor copy of the timing registers and button state
    logic [15:0] cfg_long = tbpc_pkg::LONG_PRESS_RST;
    logic [15:0] cfg_min  = tbpc_pkg::SHORT_MIN_RST;
    logic [15:0] cfg_max  = tbpc_pkg::SHORT_MAX_RST;
    logic [2:0]  lv_prev  = '0;
    logic [31:0] stamp_q [0:2] = '{default: '0};
    logic [2:0]  held_q   = '0;
    logic        fired_q  = 1'b0;

    // stimulus-side view of what has been queued
    logic [2:0]  gen_lv   = '0;
    logic [31:0] gen_stamp [0:2] = '{default: '0};
    logic [31:0] gen_now  = '0;

    tbpc_pkg::poll_t    poll_queue[$];
    tbpc_pkg::actions_t expected_actions[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned hold_left      = 0;
    int unsigned rx_tick        = 0;
    int unsigned rx_mode        = 0;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    function automatic tbpc_pkg::btn_action_t short_press(input int unsigned idx,
                                                          input logic lvl,
                                                          input logic [31:0] now,
                                                          input tbpc_pkg::sys_status_t st,
                                                          inout logic menu);
        tbpc_pkg::btn_action_t act;
        logic [31:0] dur;
        act = tbpc_pkg::BTN_ACT_NONE;
        if (lvl && !lv_prev[idx]) begin
            stamp_q[idx] = now;
            held_q[idx]  = 1'b1;
        end
        if (!lvl && lv_prev[idx] && held_q[idx]) begin
            dur = now - stamp_q[idx];
            held_q[idx] = 1'b0;
            if (dur >= {16'd0, cfg_min} && dur < {16'd0, cfg_max}) begin
                if (menu) begin
                    act = tbpc_pkg::BTN_ACT_MENU;
                end else if (st == tbpc_pkg::STATUS_IDLE) begin
                    menu = 1'b1;
                    act  = tbpc_pkg::BTN_ACT_ENTER;
                end else begin
                    act = tbpc_pkg::BTN_ACT_REFUSED;
                end
            end else begin
                act = tbpc_pkg::BTN_ACT_INVALID;
            end
        end
        return act;
    endfunction

    function automatic tbpc_pkg::actions_t classify_poll(input tbpc_pkg::poll_t p);
        tbpc_pkg::actions_t    res;
        tbpc_pkg::sys_status_t st;
        logic        menu;
        logic [31:0] dur;
        res.record_action = tbpc_pkg::REC_NONE;
        st   = tbpc_pkg::sys_status_t'(p.system_status);
        menu = p.menu_open;
        if (p.record_level && !lv_prev[tbpc_pkg::BTN_REC]) begin
            stamp_q[tbpc_pkg::BTN_REC] = p.now_ms;
            held_q[tbpc_pkg::BTN_REC]  = 1'b1;
            fired_q                    = 1'b0;
        end
        if (p.record_level && held_q[tbpc_pkg::BTN_REC] && !fired_q) begin
            dur = p.now_ms - stamp_q[tbpc_pkg::BTN_REC];
            if (dur >= {16'd0, cfg_long}) begin
                fired_q = 1'b1;
                if (st != tbpc_pkg::STATUS_TRANSMIT) begin
                    if (st == tbpc_pkg::STATUS_RECORDING) begin
                        res.record_action = tbpc_pkg::REC_STOP;
                        st = tbpc_pkg::STATUS_IDLE;
                    end else begin
                        res.record_action = menu ? tbpc_pkg::REC_CLOSE_START
                                                 : tbpc_pkg::REC_START;
                        menu = 1'b0;
                        st   = tbpc_pkg::STATUS_RECORDING;
                    end
                end
            end
        end
        if (!p.record_level && lv_prev[tbpc_pkg::BTN_REC]) held_q[tbpc_pkg::BTN_REC] = 1'b0;
        res.cursor_action = short_press(tbpc_pkg::BTN_CUR, p.cursor_level, p.now_ms, st, menu);
        res.select_action = short_press(tbpc_pkg::BTN_SEL, p.select_level, p.now_ms, st, menu);
        lv_prev = {p.select_level, p.cursor_level, p.record_level};
        return res;
    endfunction

    task automatic queue_poll(input logic [31:0] now, input logic rec, input logic cur,
                              input logic sel, input tbpc_pkg::sys_status_t st,
                              input logic menu);
        tbpc_pkg::poll_t p;
        logic [2:0] lv;
        p.now_ms        = now;
        p.record_level  = rec;
        p.cursor_level  = cur;
        p.select_level  = sel;
        p.system_status = st;
        p.menu_open     = menu;
        lv = {sel, cur, rec};
        for (int b = 0; b < 3; b++) begin
            if (lv[b] && !gen_lv[b]) gen_stamp[b] = now;
        end
        gen_lv  = lv;
        gen_now = now;
        poll_queue.push_back(p);
    endtask

    // hold time for button b, on or next to its thresholds or random within a range
    function automatic logic [31:0] pick_hold(input int unsigned b);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] d;
        if (b == tbpc_pkg::BTN_REC) begin
            lo = {16'd0, cfg_long};
            case ($urandom_range(0, 4))
                0: d = lo - 1;
                1: d = lo;
                2: d = lo + 1;
                default: d = $urandom_range(0, 2 * lo + 2);
            endcase
        end else begin
            lo = {16'd0, cfg_min};
            hi = {16'd0, cfg_max};
            case ($urandom_range(0, 5))
                0: d = lo - 1;
                1: d = lo;
                2: d = hi - 1;
                3: d = hi;
                default: d = (hi > lo) ? $urandom_range(lo, hi - 1) : $urandom_range(0, lo + 8);
            endcase
        end
        return d;
    endfunction

    task automatic add_random_polls(input int unsigned count);
        int unsigned kind;
        int unsigned b;
        logic [2:0]  lv;
        logic [31:0] now;
        tbpc_pkg::sys_status_t st;
        for (int unsigned i = 0; i < count; i++) begin
            lv   = gen_lv;
            now  = gen_now;
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                now += $urandom_range(0, 40);
                b = $urandom_range(0, 2);
                if ($urandom_range(0, 1)) lv[b] = ~lv[b];
                if (b == tbpc_pkg::BTN_REC && lv[b] && gen_lv[b] && $urandom_range(0, 1))
                    now = gen_stamp[b] + pick_hold(b);
                if (b != tbpc_pkg::BTN_REC && !lv[b] && gen_lv[b])
                    now = gen_stamp[b] + pick_hold(b);
            end else if (kind == 7) begin
                lv  = 3'($urandom_range(0, 7));
                now += $urandom_range(0, 5000);
            end else if (kind == 8) begin
                lv  = 3'($urandom_range(0, 7));
                now = $urandom;
            end else begin
                now = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            end
            st = ($urandom_range(0, 2) != 0) ? tbpc_pkg::STATUS_IDLE
                                             : tbpc_pkg::sys_status_t'($urandom_range(0, 3));
            queue_poll(now, lv[0], lv[1], lv[2], st, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            tbpc_pkg::CFG_LONG_PRESS: cfg_long = val;
            tbpc_pkg::CFG_SHORT_MIN:  cfg_min  = val;
            tbpc_pkg::CFG_SHORT_MAX:  cfg_max  = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (poll_queue.size() != 0 || s_tvalid || expected_actions.size() != 0);
    endtask

    // driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        logic        nxt_valid;
        logic [39:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_actions.push_back(classify_poll(tbpc_pkg::poll_t'(s_tdata[37:0])));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (poll_queue.size() > 0) begin
                    nxt_data  = {2'b00, poll_queue.pop_front()};
                    nxt_valid = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // monitor: checks each result word, drives m_tready
    always @(posedge aclk) begin
        tbpc_pkg::actions_t got;
        tbpc_pkg::actions_t want;
        logic     nxt_ready;
        if (!aresetn) begin
            nxt_ready = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = tbpc_pkg::actions_t'(m_tdata);
                results_seen++;
                if (expected_actions.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word %02h", m_tdata));
                end else begin
                    want = expected_actions.pop_front();
                    if (got.record_action !== want.record_action)
                        flag_mismatch($sformatf("result %0d record_action %0d, want %0d",
                                                results_seen, got.record_action,
                                                want.record_action));
                    if (got.cursor_action !== want.cursor_action)
                        flag_mismatch($sformatf("result %0d cursor_action %0d, want %0d",
                                                results_seen, got.cursor_action,
                                                want.cursor_action));
                    if (got.select_action !== want.select_action)
                        flag_mismatch($sformatf("result %0d select_action %0d, want %0d",
                                                results_seen, got.select_action,
                                                want.select_action));
                end
                if (results_seen == 150 || results_seen == 600) hold_left = HOLD_CYCLES;
            end
            rx_tick++;
            if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                case (rx_mode)
                    0: nxt_ready = 1'b1;
                    1: nxt_ready = 1'($urandom_range(0, 1));
                    2: nxt_ready = ($urandom_range(0, 9) != 0);
                    default: nxt_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
        m_tready <= nxt_ready;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[three_button_press_classifier_core] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed polls at reset timings
        queue_poll(32'd0,     0, 0, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd10,    0, 1, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd20,    0, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // enter menu
        queue_poll(32'd30,    0, 0, 1, tbpc_pkg::STATUS_IDLE, 1);
        queue_poll(32'd40,    0, 0, 0, tbpc_pkg::STATUS_IDLE, 1);   // menu select
        queue_poll(32'd50,    0, 1, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd3050,  0, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // held too long
        queue_poll(32'd3100,  0, 1, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd3100,  0, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // held zero ms
        queue_poll(32'd3101,  0, 1, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd3102,  0, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // shortest valid hold
        queue_poll(32'd4000,  1, 0, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd5999,  1, 0, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd6000,  1, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // start
        queue_poll(32'd6500,  1, 0, 0, tbpc_pkg::STATUS_IDLE, 0);   // no second fire
        queue_poll(32'd6600,  0, 1, 0, tbpc_pkg::STATUS_IDLE, 0);
        queue_poll(32'd6700,  1, 1, 0, tbpc_pkg::STATUS_IDLE, 1);
        queue_poll(32'd8700,  1, 0, 0, tbpc_pkg::STATUS_IDLE, 1);   // close+start, refused
        queue_poll(32'd8800,  0, 0, 1, tbpc_pkg::STATUS_RECORDING, 0);
        queue_poll(32'd8900,  1, 0, 1, tbpc_pkg::STATUS_RECORDING, 0);
        queue_poll(32'd10900, 1, 0, 0, tbpc_pkg::STATUS_RECORDING, 0); // stop, select enters
        queue_poll(32'd11000, 0, 0, 0, tbpc_pkg::STATUS_TRANSMIT, 0);
        queue_poll(32'd11100, 1, 0, 0, tbpc_pkg::STATUS_TRANSMIT, 0);
        queue_poll(32'd13100, 1, 1, 0, tbpc_pkg::STATUS_TRANSMIT, 0); // blocked, transmitting
        queue_poll(32'd13200, 0, 0, 0, tbpc_pkg::STATUS_OTHER, 0);     // refused
        queue_poll(32'hFFFF_FF00, 1, 0, 1, tbpc_pkg::STATUS_OTHER, 0);
        queue_poll(32'h0000_07D0, 1, 0, 0, tbpc_pkg::STATUS_OTHER, 1); // wrapped hold, close+start
        queue_poll(32'hFFFF_FFFF, 0, 0, 0, tbpc_pkg::STATUS_IDLE, 1);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            repeat (2) @(posedge aclk);
            case (ph)
                0: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, 16'd0);
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  16'd0);
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  16'd1);
                end
                1: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, 16'hFFFF);
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  16'hFFFF);
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  16'hFFFF);
                    write_reg(CFG_ADDR_UNUSED, 16'h0005);
                end
                2: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, 16'd1);
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  16'd0);
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  16'd0);
                end
                3: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, 16'($urandom_range(1, 300)));
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  16'($urandom_range(0, 60)));
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  16'($urandom_range(cfg_min + 1, 500)));
                end
                4: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, 16'($urandom_range(1, 65535)));
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  16'($urandom_range(0, 65535)));
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  16'($urandom_range(0, 65535)));
                end
                default: begin
                    write_reg(tbpc_pkg::CFG_LONG_PRESS, tbpc_pkg::LONG_PRESS_RST);
                    write_reg(tbpc_pkg::CFG_SHORT_MIN,  tbpc_pkg::SHORT_MIN_RST);
                    write_reg(tbpc_pkg::CFG_SHORT_MAX,  tbpc_pkg::SHORT_MAX_RST);
                end
            endcase
            @(negedge aclk);
            add_random_polls(180);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (expected_actions.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_actions.size()));
        if (mismatch_count == 0) begin
            $display("[three_button_press_classifier_core] OK");
        end else begin
            $display("[three_button_press_classifier_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/tbpc_pkg.sv
src/tbpc_decide.sv
src/three_button_press_classifier_core.sv
tb/sv/three_button_press_classifier_core_tb.sv
